// File: design/glrs_pkg.sv
package glrs_pkg;

  localparam int NumIrqs  = 1024;
  localparam int IrqW     = 10;
  localparam int SlotW    = 6;
  localparam int SgiCount = 16;
  localparam int PrioShift = 3;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_POPULATE = 2'd1,
    CMD_FOLD     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_OUT  = 2'd2
  } state_e;

  typedef struct packed {
    logic            level;
    logic            hw;
    logic [IrqW-1:0] hwintid;
    logic [7:0]      priority_v;
    logic            latch;
    logic            active;
    logic            line;
    logic [7:0]      sources;
  } rec_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [IrqW-1:0]  intid;
    logic [SlotW-1:0] lr_index;
    logic             level_config;
    logic             hw_mapped;
    logic [IrqW-1:0]  hw_intid;
    logic [7:0]       priority_req;
    logic             pending;
    logic             active;
    logic             line_sample;
    logic [7:0]       sgi_sources;
    logic [2:0]       lr_source;
  } in_word_t;

  typedef struct packed {
    logic [SlotW-1:0] lr_index_out;
    logic [IrqW-1:0]  lr_virq;
    logic             lr_pending;
    logic             lr_active;
    logic             lr_hw;
    logic [IrqW-1:0]  lr_pirq;
    logic             lr_eoi;
    logic [2:0]       lr_src_cpu;
    logic [4:0]       lr_priority;
    logic             clear_in_progress;
    logic             deactivate_physical;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input word, start record read
    logic execute;   // compute result and write record back
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_result;
    logic clearing;  // record table sweep after reset still running
  } dp_stat_t;

endpackage

// File: design/glrs_if.sv
interface glrs_in_if;
  import glrs_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface glrs_out_if;
  import glrs_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/glrs_ctrl.sv
module glrs_ctrl
  import glrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !stat_i.clearing) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = stat_i.has_result ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE) && !stat_i.clearing;
    out_valid_o   = (state_q == ST_OUT);
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i && !stat_i.clearing;
    cmd_o.execute = (state_q == ST_READ);
  end

endmodule

// File: design/glrs_dp.sv
module glrs_dp
  import glrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o,
  output out_word_t out_data_o
);

  rec_t            mem_q [NumIrqs];
  in_word_t        word_q;
  rec_t            rd_q;
  out_word_t       res_q, res_d;
  rec_t            r, nr;
  logic            wr_en;
  logic            sgi, pend, pend2, lr_p, lr_a;
  logic [2:0]      src;
  logic [7:0]      bitm;
  logic            clr_busy_q, clr_busy_d;
  logic [IrqW-1:0] clr_idx_q, clr_idx_d;

  // Sweep the record table to zero after reset, one entry per cycle.
  always_comb begin
    clr_idx_d  = clr_idx_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + IrqW'(1);
      if (clr_idx_q == IrqW'(NumIrqs - 1)) clr_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  // Record storage, one registered read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q   <= mem_q[in_data_i.intid];
      word_q <= in_data_i;
    end
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (wr_en) begin
      mem_q[word_q.intid] <= nr;
    end
    if (cmd_i.execute) res_q <= res_d;
  end

  assign stat_o.has_result = (word_q.command == CMD_POPULATE) ||
                             (word_q.command == CMD_FOLD);
  assign stat_o.clearing   = clr_busy_q;
  assign out_data_o = res_q;

  always_comb begin
    r     = rd_q;
    nr    = r;
    res_d = '0;
    wr_en = 1'b0;
    sgi   = (word_q.intid < IrqW'(SgiCount));
    pend  = 1'b0;
    pend2 = 1'b0;
    src   = '0;
    bitm  = r.sources;
    lr_p  = word_q.pending;
    lr_a  = word_q.active;
    res_d.lr_index_out = word_q.lr_index;
    res_d.lr_virq      = word_q.intid;
    case (word_q.command)
      CMD_WRITE: begin
        wr_en         = cmd_i.execute;
        nr.level      = word_q.level_config;
        nr.hw         = word_q.hw_mapped;
        nr.hwintid    = word_q.hw_intid;
        nr.priority_v = word_q.priority_req;
        nr.latch      = word_q.pending;
        nr.active     = word_q.active;
        nr.line       = word_q.line_sample;
        nr.sources    = word_q.sgi_sources;
      end
      CMD_POPULATE: begin
        wr_en = cmd_i.execute;
        if (r.latch || (r.level && r.line)) begin
          pend = 1'b1;
          if (!r.level) nr.latch = 1'b0;
          if (sgi) begin
            for (int b = 7; b >= 0; b--) begin
              if (r.sources[b]) src = 3'(b);
            end
            if (r.sources != '0) bitm[src] = 1'b0;
            nr.sources = bitm;
            if (bitm != '0) nr.latch = 1'b1;
          end
        end
        pend2 = pend;
        if (r.hw) begin
          res_d.lr_hw   = 1'b1;
          res_d.lr_pirq = r.hwintid;
          if (r.active && (nr.latch || (r.level && r.line))) pend2 = 1'b0;
        end else if (r.level) begin
          res_d.lr_eoi = 1'b1;
        end
        if (r.hw && r.level && pend2) nr.line = 1'b0;
        res_d.lr_pending  = pend2;
        res_d.lr_active   = r.active;
        res_d.lr_src_cpu  = src;
        res_d.lr_priority = r.priority_v[7:PrioShift];
      end
      CMD_FOLD: begin
        wr_en = cmd_i.execute;
        if (r.hw && !lr_a && !lr_p) res_d.clear_in_progress = 1'b1;
        nr.active = lr_a;
        if (!r.level && lr_p) begin
          nr.latch = 1'b1;
          if (sgi) nr.sources[word_q.lr_source] = 1'b1;
        end
        if (r.level && !lr_p) nr.latch = 1'b0;
        if (r.hw && r.level && lr_p) begin
          nr.line = word_q.line_sample;
          if (!word_q.line_sample) res_d.deactivate_physical = 1'b1;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

endmodule

// File: design/gicv2_list_register_sync.sv
// Channel | Dir | Word            | Handshake
// in_ch   | in  | command, fields | valid/ready, accept on both high
// out_ch  | out | list reg fields | valid/ready, accept on both high
//
// A write word is captured with its record read, then executed and written
// back. A populate or fold word also passes through the output register;
// hold the result there until taken, and accept the next word only after that.
// Write and unknown commands give no result. After reset, sweep the record
// table to zero and hold off the input until the sweep is done.
module gicv2_list_register_sync
  import glrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  glrs_in_if.sink     in_ch,
  glrs_out_if.source  out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  glrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  glrs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_ch.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_ch.data)
  );

endmodule

// File: verif/glrs_checker.sv
`timescale 1ns / 1ps

module glrs_checker
  import glrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  glrs_in_if.sink    in_mon,
  glrs_out_if.sink   out_mon,
  output int         fail_count_o,
  output int         lr_pending_count_o
);

  rec_t      irq_table [NumIrqs];
  out_word_t lr_expected_q [$];
  int        mismatches;

  assign fail_count_o       = mismatches;
  assign lr_pending_count_o = lr_expected_q.size();

  function automatic logic rec_is_pending(rec_t r);
    return r.latch || (r.level && r.line);
  endfunction

  // Apply one command word to the shadow table; return 1 with the LR word if it yields one.
  function automatic logic sync_lr_word(in_word_t w, output out_word_t lr);
    rec_t   r;
    logic   in_range;
    logic   pend;
    logic   is_sgi;
    logic [2:0] src;
    in_range = w.intid < NumIrqs;
    is_sgi   = w.intid < SgiCount;
    r  = in_range ? irq_table[w.intid] : '0;
    lr = '0;
    case (cmd_e'(w.command))
      CMD_WRITE: begin
        if (in_range) begin
          r.level = w.level_config;
          r.hw = w.hw_mapped;
          r.hwintid = w.hw_intid;
          r.priority_v = w.priority_req;
          r.latch = w.pending;
          r.active = w.active;
          r.line = w.line_sample;
          r.sources = w.sgi_sources;
          irq_table[w.intid] = r;
        end
        return 1'b0;
      end
      CMD_POPULATE: begin
        lr.lr_index_out = w.lr_index;
        lr.lr_virq = w.intid;
        pend = 1'b0;
        src = '0;
        if (rec_is_pending(r)) begin
          pend = 1'b1;
          if (!r.level) r.latch = 1'b0;
          if (is_sgi) begin
            for (int b = 0; b < 8; b++) begin
              if (r.sources[b]) begin
                src = b[2:0];
                r.sources[b] = 1'b0;
                break;
              end
            end
            if (r.sources != 0) r.latch = 1'b1;
          end
        end
        if (r.hw) begin
          lr.lr_hw = 1'b1;
          lr.lr_pirq = r.hwintid;
          if (r.active && rec_is_pending(r)) pend = 1'b0;
        end else if (r.level) begin
          lr.lr_eoi = 1'b1;
        end
        if (r.hw && r.level && pend) r.line = 1'b0;
        lr.lr_pending = pend;
        lr.lr_active = r.active;
        lr.lr_src_cpu = src;
        lr.lr_priority = r.priority_v[7:PrioShift];
        if (in_range) irq_table[w.intid] = r;
        return 1'b1;
      end
      CMD_FOLD: begin
        lr.lr_index_out = w.lr_index;
        lr.lr_virq = w.intid;
        if (r.hw && !w.active && !w.pending) lr.clear_in_progress = 1'b1;
        r.active = w.active;
        if (!r.level && w.pending) begin
          r.latch = 1'b1;
          if (is_sgi) r.sources[w.lr_source] = 1'b1;
        end
        if (r.level && !w.pending) r.latch = 1'b0;
        if (r.hw && r.level && w.pending) begin
          r.line = w.line_sample;
          if (!w.line_sample) lr.deactivate_physical = 1'b1;
        end
        if (in_range) irq_table[w.intid] = r;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t lr;
    out_word_t exp_w;
    if (!rst_ni) begin
      foreach (irq_table[i]) irq_table[i] = '0;
      lr_expected_q.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (lr_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", out_mon.data);
        end else begin
          exp_w = lr_expected_q.pop_front();
          if (exp_w !== out_mon.data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_w, out_mon.data);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        if (sync_lr_word(in_mon.data, lr)) lr_expected_q.push_back(lr);
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import glrs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   lr_outstanding;
  int   idle_pct;      // sender idle chance, percent
  int   stall_pct;     // receiver stall chance, percent
  int   hold_cycles;   // long receiver hold-off, counted below

  glrs_in_if  in_ch ();
  glrs_out_if out_ch ();

  gicv2_list_register_sync dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  glrs_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_mon             (in_ch.sink),
    .out_mon            (out_ch.sink),
    .fail_count_o       (fail_count),
    .lr_pending_count_o (lr_outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop well past the slowest legal run.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, or a full hold-off while hold_cycles runs down.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Random command word; mostly small record space so writes and reads collide.
  function automatic in_word_t rand_word();
    in_word_t    w;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    w = rnd[$bits(in_word_t)-1:0];
    case ($urandom_range(9))
      0, 1, 2: w.command = CMD_WRITE;
      3, 4, 5: w.command = CMD_POPULATE;
      6, 7, 8: w.command = CMD_FOLD;
      default: w.command = CMD_NONE;
    endcase
    if ($urandom_range(3) != 0) w.intid = 10'($urandom_range(23));
    return w;
  endfunction

  // Offer one word and hold it until ready is seen high after a rising edge;
  // valid stays up for the next word, drain_results drops it.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (lr_outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    in_word_t w;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: populate reset records, SGI source walk, hw active, extremes.
    w = '0; w.command = CMD_POPULATE; w.intid = 10'd1023; w.lr_index = 6'd63;
    send_word(w);
    w = '0; w.command = CMD_WRITE; w.intid = 10'd3; w.pending = 1'b1;
    w.sgi_sources = 8'b1010_0000; w.priority_req = 8'hff;
    send_word(w);
    w.command = CMD_POPULATE; send_word(w); send_word(w); send_word(w);
    // SGI pending with no source
    w = '0; w.command = CMD_WRITE; w.intid = 10'd0; w.pending = 1'b1;
    send_word(w);
    w.command = CMD_POPULATE; send_word(w);
    // hardware level, pending and active
    w = '1; w.command = CMD_WRITE; w.intid = 10'd40; send_word(w);
    w.command = CMD_POPULATE; send_word(w);
    w.command = CMD_WRITE; w.active = 1'b0; w.hw_intid = 10'd5; send_word(w);
    w.command = CMD_POPULATE; send_word(w);
    // fold variants on hardware level record
    w = '0; w.command = CMD_FOLD; w.intid = 10'd40; w.pending = 1'b1; send_word(w);
    w.line_sample = 1'b1; send_word(w);
    w.pending = 1'b0; send_word(w);
    w = '0; w.command = CMD_FOLD; w.intid = 10'd7; w.pending = 1'b1;
    w.lr_source = 3'd7; send_word(w);
    w.command = CMD_POPULATE; send_word(w);
    w = '0; w.command = CMD_NONE; w.intid = 10'd7; send_word(w);
    w = '1; w.command = CMD_WRITE; w.intid = 10'd500; w.level_config = 1'b0;
    w.hw_mapped = 1'b0; send_word(w);
    w.command = CMD_POPULATE; send_word(w);
    drain_results();

    // Long receiver hold-off while words keep coming, so the input backs up.
    hold_cycles = 300;
    repeat (20) send_word(rand_word());
    drain_results();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 27 : 0;
      stall_pct = (ph == 2) ? 45 : (ph == 3) ? 27 : 0;
      repeat (330) send_word(rand_word());
      drain_results();  // sender pauses until every result is back
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
